// ----- hdl/csl_pkg.sv -----
package csl_pkg;

  typedef enum logic [2:0] {
    M_IDLE,
    M_WORD,
    M_LIT,
    M_ESC,
    M_PLUS,
    M_SLASH,
    M_COMMENT
  } mode_t;

  typedef struct packed {
    logic       done;
    logic [4:0] kind;
    logic [7:0] data;
  } res_t;

  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [4:0] K_IDENT        = 5'd0;
  localparam logic [4:0] K_NUMBER       = 5'd1;
  localparam logic [4:0] K_KW_BASE      = 5'd2;
  localparam logic [4:0] K_CHARLIT      = 5'd7;
  localparam logic [4:0] K_STRINGLIT    = 5'd8;
  localparam logic [4:0] K_LPAREN       = 5'd9;
  localparam logic [4:0] K_RPAREN       = 5'd10;
  localparam logic [4:0] K_LBRACE       = 5'd11;
  localparam logic [4:0] K_RBRACE       = 5'd12;
  localparam logic [4:0] K_COMMA        = 5'd13;
  localparam logic [4:0] K_SEMI         = 5'd14;
  localparam logic [4:0] K_ASSIGN       = 5'd15;
  localparam logic [4:0] K_LESS         = 5'd16;
  localparam logic [4:0] K_GREATER      = 5'd17;
  localparam logic [4:0] K_STAR         = 5'd18;
  localparam logic [4:0] K_AMP          = 5'd19;
  localparam logic [4:0] K_PLUS         = 5'd20;
  localparam logic [4:0] K_PLUSPLUS     = 5'd21;
  localparam logic [4:0] K_SLASH        = 5'd22;
  localparam logic [4:0] K_UNTERMINATED = 5'd23;

  localparam int NKW = 5;

  localparam logic [63:0] KW_STR [NKW] = '{
    {"return", 16'h0000},
    {"while", 24'h000000},
    {"void", 32'h00000000},
    {"int", 40'h0000000000},
    {"char", 32'h00000000}
  };

  localparam logic [2:0] KW_LEN [NKW] = '{3'd6, 3'd5, 3'd4, 3'd3, 3'd4};

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic [7:0] kw_char(input int i, input logic [2:0] pos);
    logic [63:0] s;
    s = KW_STR[i] << {pos, 3'b000};
    return s[63:56];
  endfunction

  function automatic logic [4:0] match_at(input logic [2:0] pos, input logic [7:0] b,
                                          input logic [4:0] cands);
    logic [4:0] keep;
    keep = '0;
    for (int i = 0; i < NKW; i++) begin
      if (cands[i] && pos < KW_LEN[i] && kw_char(i, pos) == b) keep[i] = 1'b1;
    end
    return keep;
  endfunction

  function automatic logic [4:0] word_kind(input logic num, input logic [4:0] cands,
                                           input logic [2:0] len);
    logic [4:0] k;
    k = K_IDENT;
    for (int i = NKW - 1; i >= 0; i--) begin
      if (cands[i] && KW_LEN[i] == len) k = K_KW_BASE + 5'(i);
    end
    if (num) k = K_NUMBER;
    return k;
  endfunction

  function automatic logic [5:0] punct_kind(input logic [7:0] b);
    logic [5:0] r;
    unique case (b)
      "(":     r = {1'b1, K_LPAREN};
      ")":     r = {1'b1, K_RPAREN};
      "{":     r = {1'b1, K_LBRACE};
      "}":     r = {1'b1, K_RBRACE};
      ",":     r = {1'b1, K_COMMA};
      ";":     r = {1'b1, K_SEMI};
      "=":     r = {1'b1, K_ASSIGN};
      "<":     r = {1'b1, K_LESS};
      ">":     r = {1'b1, K_GREATER};
      "*":     r = {1'b1, K_STAR};
      "&":     r = {1'b1, K_AMP};
      default: r = {1'b0, K_IDENT};
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/csl_front.sv -----
module csl_front
  import csl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // text_byte_in
  input  logic       s_tlast,   // end_of_text
  input  q_stat_t    q_stat,
  output logic       push,
  output bundle_t    push_data
);

  mode_t      mode, mode_next;
  logic       lit_char, lit_char_next;
  logic       word_num, word_num_next;
  logic [4:0] cands, cands_next;
  logic [2:0] wlen, wlen_next;

  logic [7:0] b;
  logic       alnum;
  logic [5:0] pk;
  logic       accept;

  logic       id_emit;
  res_t       id_res;
  mode_t      id_mode;
  logic       id_lit;
  logic       id_num;
  logic [4:0] id_cands;
  logic [2:0] id_len;

  logic [1:0] n;
  res_t       r0, r1;

  assign b        = s_tdata;
  assign alnum    = is_letter(b) || is_digit(b);
  assign pk       = punct_kind(b);
  assign s_tready = !q_stat.full;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    id_emit  = 1'b0;
    id_res   = '0;
    id_mode  = M_IDLE;
    id_lit   = 1'b0;
    id_num   = 1'b0;
    id_cands = '0;
    id_len   = '0;
    if (alnum) begin
      id_mode  = M_WORD;
      id_num   = is_digit(b);
      id_cands = match_at(3'd0, b, 5'h1f);
      id_len   = 3'd1;
      id_emit  = 1'b1;
      id_res   = '{done: 1'b0, kind: K_IDENT, data: b};
    end else if (b == "\"") begin
      id_mode = M_LIT;
    end else if (b == "'") begin
      id_mode = M_LIT;
      id_lit  = 1'b1;
    end else if (pk[5]) begin
      id_emit = 1'b1;
      id_res  = '{done: 1'b1, kind: pk[4:0], data: 8'h00};
    end else if (b == "+") begin
      id_mode = M_PLUS;
    end else if (b == "/") begin
      id_mode = M_SLASH;
    end
  end

  always_comb begin
    mode_next     = mode;
    lit_char_next = lit_char;
    word_num_next = word_num;
    cands_next    = cands;
    wlen_next     = wlen;
    n             = 2'd0;
    r0            = '0;
    r1            = '0;
    if (s_tlast) begin
      unique case (mode)
        M_WORD: begin
          n  = 2'd1;
          r0 = '{done: 1'b1, kind: word_kind(word_num, cands, wlen), data: 8'h00};
        end
        M_LIT, M_ESC: begin
          n  = 2'd1;
          r0 = '{done: 1'b1, kind: K_UNTERMINATED, data: 8'h00};
        end
        M_PLUS: begin
          n  = 2'd1;
          r0 = '{done: 1'b1, kind: K_PLUS, data: 8'h00};
        end
        M_SLASH: begin
          n  = 2'd1;
          r0 = '{done: 1'b1, kind: K_SLASH, data: 8'h00};
        end
        default: n = 2'd0;
      endcase
      mode_next     = M_IDLE;
      lit_char_next = 1'b0;
      word_num_next = 1'b0;
      cands_next    = '0;
      wlen_next     = '0;
    end else begin
      unique case (mode)
        M_WORD: begin
          if (alnum) begin
            cands_next = match_at(wlen, b, cands);
            if (wlen != 3'd7) wlen_next = wlen + 3'd1;
            n  = 2'd1;
            r0 = '{done: 1'b0, kind: K_IDENT, data: b};
          end else begin
            n  = 2'd1;
            r0 = '{done: 1'b1, kind: word_kind(word_num, cands, wlen), data: 8'h00};
          end
        end
        M_LIT: begin
          if (b == (lit_char ? 8'("'") : 8'("\""))) begin
            n         = 2'd1;
            r0        = '{done: 1'b1, kind: lit_char ? K_CHARLIT : K_STRINGLIT, data: 8'h00};
            mode_next = M_IDLE;
          end else if (b == "\\") begin
            mode_next = M_ESC;
          end else begin
            n  = 2'd1;
            r0 = '{done: 1'b0, kind: K_IDENT, data: b};
          end
        end
        M_ESC: begin
          n         = 2'd1;
          r0        = '{done: 1'b0, kind: K_IDENT, data: (b == "n") ? 8'h0a : b};
          mode_next = M_LIT;
        end
        M_PLUS: begin
          n = 2'd1;
          if (b == "+") begin
            r0        = '{done: 1'b1, kind: K_PLUSPLUS, data: 8'h00};
            mode_next = M_IDLE;
          end else begin
            r0 = '{done: 1'b1, kind: K_PLUS, data: 8'h00};
          end
        end
        M_SLASH: begin
          if (b == "/") begin
            mode_next = M_COMMENT;
          end else begin
            n  = 2'd1;
            r0 = '{done: 1'b1, kind: K_SLASH, data: 8'h00};
          end
        end
        M_COMMENT: begin
          if (b == 8'h0a) mode_next = M_IDLE;
        end
        default: n = 2'd0;
      endcase

      // hand the byte to the idle classifier when idle or after a closed word or operator
      if ((mode == M_WORD && !alnum) || (mode == M_PLUS && b != "+") ||
          (mode == M_SLASH && b != "/") || mode == M_IDLE) begin
        mode_next     = id_mode;
        lit_char_next = id_lit;
        word_num_next = id_num;
        cands_next    = id_cands;
        wlen_next     = id_len;
        if (id_emit) begin
          if (mode == M_IDLE) begin
            n  = 2'd1;
            r0 = id_res;
          end else begin
            n  = 2'd2;
            r1 = id_res;
          end
        end
      end
    end
  end

  assign push      = accept && (n != 2'd0);
  assign push_data = '{two: (n == 2'd2), r0: r0, r1: r1};

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= M_IDLE;
      lit_char <= 1'b0;
      word_num <= 1'b0;
      cands    <= '0;
      wlen     <= '0;
    end else if (accept) begin
      mode     <= mode_next;
      lit_char <= lit_char_next;
      word_num <= word_num_next;
      cands    <= cands_next;
      wlen     <= wlen_next;
    end
  end

endmodule

// ----- hdl/csl_queue.sv -----
module csl_queue
  import csl_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t push_data,
  input  logic    pop,
  output bundle_t head,
  output q_stat_t q_stat
);

  bundle_t        mem [QDEPTH];
  logic [QAW-1:0] wptr, rptr;
  logic [QAW:0]   count;

  assign head         = mem[rptr];
  assign q_stat.full  = (count == (QAW+1)'(QDEPTH));
  assign q_stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      count <= count + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && q_stat.full && !pop))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && q_stat.empty))
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QAW+1)'(QDEPTH))
    else $error("queue count out of range");
`endif

endmodule

// ----- hdl/csl_back.sv -----
module csl_back
  import csl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  bundle_t     head,
  input  q_stat_t     q_stat,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // kind, content_byte
  output logic        m_tuser,   // token_done
  output logic        m_tlast    // last_of_run
);

  logic out_valid;
  res_t out_res;
  logic out_last;
  logic pos;

  logic load;
  res_t cur;
  logic cur_last;

  assign load     = !q_stat.empty && (!out_valid || m_tready);
  assign cur      = pos ? head.r1 : head.r0;
  assign cur_last = pos || !head.two;
  assign pop      = load && cur_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
      pos       <= !cur_last;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res  <= cur;
      out_last <= cur_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_res.data, out_res.kind};
  assign m_tuser  = out_res.done;
  assign m_tlast  = out_last;

endmodule

// ----- hdl/c_subset_lexer.sv -----
// c_subset_lexer: byte-serial tokenizer for a small C subset.
// Input stream s_*: one source byte per request in s_tdata[7:0]; s_tlast
//   marks end of text (the data byte is then ignored) and flushes any
//   pending word, operator or open literal.
// Output stream m_*: one result per request. m_tuser=1 is a token
//   completion with its kind in m_tdata[4:0]; m_tuser=0 carries one content
//   byte in m_tdata[12:5]. m_tlast marks the final result of an input byte.
// A byte's results pass through the queue and then the output register.
// Throughput: one byte per cycle while each byte gives at most one result
//   and neither the queue nor the receiver stalls; a byte that closes a word
//   or operator and starts a new token gives two results, which the output
//   register takes in turn; it drains one result per cycle while m_tready=1.
// A four-entry queue between the classifier and the output stage absorbs
//   bursts; s_tready drops only when that queue is full.
// Reset: synchronous, clears the scanner state, the queue and the output.
// When the receiver stalls, the held result stays on m_* and input is taken
//   until the queue fills.
module c_subset_lexer
  import csl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // text_byte_in
  input  logic        s_tlast,   // end_of_text
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // kind [4:0], content_byte [12:5]
  output logic        m_tuser,   // token_done
  output logic        m_tlast    // last_of_run
);

  logic    push;
  bundle_t push_data;
  logic    pop;
  bundle_t head;
  q_stat_t q_stat;

  csl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  csl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  csl_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_stat   (q_stat),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ----- sim/tb_c_subset_lexer.sv -----
module tb_c_subset_lexer;
  import csl_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_BYTES = 120;

  typedef struct {
    logic [7:0] text;
    logic       eot;
  } text_item_t;

  typedef struct {
    logic       done;
    logic [4:0] kind;
    logic [7:0] text;
    logic       last;
  } token_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;   // kind [4:0], content_byte [12:5]
  logic        m_tuser;   // token_done
  logic        m_tlast;   // last_of_run

  text_item_t text_q[$];
  token_res_t tok_expect_q[$];
  token_res_t step_res[$];

  string kw_words[5] = '{"return", "while", "void", "int", "char"};

  mode_t      lx_mode = M_IDLE;
  logic       lx_char_lit = 1'b0;
  logic       lx_number = 1'b0;
  logic [4:0] lx_cands = '0;
  logic [2:0] lx_len = '0;

  int mismatches = 0;
  int bytes_sent = 0;
  int eot_sent = 0;
  int tokens_seen = 0;
  int quiet_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  logic [5:0] rx_count = '0;
  int rx_style = 0;

  c_subset_lexer i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #10 clk = ~clk;

  function automatic logic is_word_byte(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_" ||
           (b >= "0" && b <= "9");
  endfunction

  function automatic logic [4:0] narrow_cands(logic [2:0] pos, logic [7:0] b,
                                              logic [4:0] cands);
    logic [4:0] keep;
    keep = '0;
    for (int i = 0; i < 5; i++) begin
      if (cands[i] && pos < kw_words[i].len() && kw_words[i][pos] == b) keep[i] = 1'b1;
    end
    return keep;
  endfunction

  function automatic logic [4:0] word_class();
    if (lx_number) return K_NUMBER;
    for (int i = 0; i < 5; i++) begin
      if (lx_cands[i] && kw_words[i].len() == lx_len) return K_KW_BASE + 5'(i);
    end
    return K_IDENT;
  endfunction

  function automatic void add_res(logic done, logic [4:0] kind, logic [7:0] text);
    token_res_t r;
    r.done = done;
    r.kind = kind;
    r.text = text;
    r.last = 1'b0;
    step_res.push_back(r);
  endfunction

  function automatic void clear_lexer();
    lx_mode = M_IDLE;
    lx_char_lit = 1'b0;
    lx_number = 1'b0;
    lx_cands = '0;
    lx_len = '0;
  endfunction

  function automatic void start_token(logic [7:0] b);
    if (is_word_byte(b)) begin
      lx_mode = M_WORD;
      lx_number = (b >= "0" && b <= "9");
      lx_cands = narrow_cands(3'd0, b, 5'b11111);
      lx_len = 3'd1;
      add_res(1'b0, K_IDENT, b);
    end else begin
      case (b)
        "\"": begin
          lx_mode = M_LIT;
          lx_char_lit = 1'b0;
        end
        "'": begin
          lx_mode = M_LIT;
          lx_char_lit = 1'b1;
        end
        "(": add_res(1'b1, K_LPAREN, 8'h00);
        ")": add_res(1'b1, K_RPAREN, 8'h00);
        "{": add_res(1'b1, K_LBRACE, 8'h00);
        "}": add_res(1'b1, K_RBRACE, 8'h00);
        ",": add_res(1'b1, K_COMMA, 8'h00);
        ";": add_res(1'b1, K_SEMI, 8'h00);
        "=": add_res(1'b1, K_ASSIGN, 8'h00);
        "<": add_res(1'b1, K_LESS, 8'h00);
        ">": add_res(1'b1, K_GREATER, 8'h00);
        "*": add_res(1'b1, K_STAR, 8'h00);
        "&": add_res(1'b1, K_AMP, 8'h00);
        "+": lx_mode = M_PLUS;
        "/": lx_mode = M_SLASH;
        default: ;
      endcase
    end
  endfunction

  function automatic void lex_predict(logic [7:0] b, logic eot);
    step_res.delete();
    if (eot) begin
      case (lx_mode)
        M_WORD:        add_res(1'b1, word_class(), 8'h00);
        M_LIT, M_ESC:  add_res(1'b1, K_UNTERMINATED, 8'h00);
        M_PLUS:        add_res(1'b1, K_PLUS, 8'h00);
        M_SLASH:       add_res(1'b1, K_SLASH, 8'h00);
        default: ;
      endcase
      clear_lexer();
    end else begin
      case (lx_mode)
        M_WORD: begin
          if (is_word_byte(b)) begin
            lx_cands = narrow_cands(lx_len, b, lx_cands);
            if (lx_len != 3'd7) lx_len = lx_len + 3'd1;
            add_res(1'b0, K_IDENT, b);
          end else begin
            add_res(1'b1, word_class(), 8'h00);
            clear_lexer();
            start_token(b);
          end
        end
        M_LIT: begin
          if (b == (lx_char_lit ? 8'("'") : 8'("\""))) begin
            add_res(1'b1, lx_char_lit ? K_CHARLIT : K_STRINGLIT, 8'h00);
            clear_lexer();
          end else if (b == "\\") begin
            lx_mode = M_ESC;
          end else begin
            add_res(1'b0, K_IDENT, b);
          end
        end
        M_ESC: begin
          add_res(1'b0, K_IDENT, (b == "n") ? 8'h0a : b);
          lx_mode = M_LIT;
        end
        M_PLUS: begin
          if (b == "+") begin
            add_res(1'b1, K_PLUSPLUS, 8'h00);
            lx_mode = M_IDLE;
          end else begin
            add_res(1'b1, K_PLUS, 8'h00);
            lx_mode = M_IDLE;
            start_token(b);
          end
        end
        M_SLASH: begin
          if (b == "/") begin
            lx_mode = M_COMMENT;
          end else begin
            add_res(1'b1, K_SLASH, 8'h00);
            lx_mode = M_IDLE;
            start_token(b);
          end
        end
        M_COMMENT: begin
          if (b == 8'h0a) lx_mode = M_IDLE;
        end
        default: begin
          clear_lexer();
          start_token(b);
        end
      endcase
    end
    if (step_res.size() != 0) step_res[step_res.size() - 1].last = 1'b1;
    foreach (step_res[i]) tok_expect_q.push_back(step_res[i]);
  endfunction

  task automatic push_byte(logic [7:0] b);
    text_item_t it;
    it.text = b;
    it.eot = 1'b0;
    text_q.push_back(it);
  endtask

  task automatic push_eot();
    text_item_t it;
    it.text = 8'($urandom_range(0, 255));
    it.eot = 1'b1;
    text_q.push_back(it);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic push_literal(logic [7:0] quote);
    int n;
    logic [7:0] b;
    n = $urandom_range(0, 6);
    push_byte(quote);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        push_byte("\\");
        case ($urandom_range(0, 2))
          0: push_byte("n");
          1: push_byte(quote);
          default: push_byte(8'($urandom_range(0, 255)));
        endcase
      end else begin
        do b = 8'($urandom_range(0, 255)); while (b == quote || b == "\\");
        push_byte(b);
      end
    end
    if ($urandom_range(0, 9) != 0) push_byte(quote);
  endtask

  task automatic push_word(logic first_digit);
    string letters;
    int n;
    letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    n = $urandom_range(1, 9);
    if (first_digit) push_byte(8'($urandom_range("0", "9")));
    else push_byte(letters[$urandom_range(0, 52)]);
    for (int i = 1; i < n; i++) push_byte(letters[$urandom_range(0, letters.len() - 1)]);
  endtask

  task automatic push_random_token();
    string kw;
    string punct;
    int n;
    logic [7:0] b;
    punct = "(){},;=<>*&+/";
    case ($urandom_range(0, 19))
      0, 1, 2, 3: begin
        kw = kw_words[$urandom_range(0, 4)];
        case ($urandom_range(0, 3))
          0: kw = kw.substr(0, $urandom_range(0, kw.len() - 2));
          1: kw = {kw, "x"};
          default: ;
        endcase
        push_text(kw);
        if ($urandom_range(0, 1) == 0) push_byte(" ");
      end
      4, 5:    push_word(1'b0);
      6:       push_word(1'b1);
      7, 8:    push_literal("\"");
      9:       push_literal("'");
      10, 11, 12: push_byte(punct[$urandom_range(0, punct.len() - 1)]);
      13:      push_text("++");
      14: begin
        push_text("//");
        n = $urandom_range(0, 5);
        for (int i = 0; i < n; i++) begin
          do b = 8'($urandom_range(0, 255)); while (b == 8'h0a);
          push_byte(b);
        end
        push_byte(8'h0a);
      end
      15, 16: begin
        case ($urandom_range(0, 2))
          0: push_byte(" ");
          1: push_byte(8'h09);
          default: push_byte(8'h0a);
        endcase
      end
      17:      push_byte(8'($urandom_range(0, 255)));
      18:      push_eot();
      default: push_byte(8'($urandom_range(128, 255)));
    endcase
  endtask

  // sender: bursts with random gaps, hold while stalled
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tlast <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        lex_predict(s_tdata, s_tlast);
        bytes_sent++;
        if (s_tlast) eot_sent++;
        void'(text_q.pop_front());
      end
      if (s_tvalid && !s_tready) begin
      end else if (gap_left != 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (text_q.size() != 0) begin
        s_tvalid <= 1'b1;
        s_tdata <= text_q[0].text;
        s_tlast <= text_q[0].eot;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: switch stall style each time the 6-bit cycle counter wraps
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_count <= '0;
      rx_style = 0;
    end else begin
      rx_count <= rx_count + 6'd1;
      if (rx_count == 6'd63) rx_style = $urandom_range(0, 3);
      case (rx_style)
        0:       m_tready <= 1'b1;
        1:       m_tready <= ($urandom_range(0, 1) == 0);
        2:       m_tready <= ($urandom_range(0, 4) == 0);
        default: m_tready <= rx_count[4];
      endcase
    end
  end

  always @(posedge clk) begin
    token_res_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (tok_expect_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got tuser=%0d tdata=%h tlast=%0d",
                 $time, m_tuser, m_tdata, m_tlast);
        mismatches++;
      end else begin
        e = tok_expect_q.pop_front();
        tokens_seen++;
        if (m_tuser !== e.done) begin
          $display("%0t: token_done expected %0d actual %0d", $time, e.done, m_tuser);
          mismatches++;
        end
        if (m_tdata[4:0] !== e.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, e.kind, m_tdata[4:0]);
          mismatches++;
        end
        if (m_tdata[12:5] !== e.text) begin
          $display("%0t: content_byte expected %h actual %h", $time, e.text, m_tdata[12:5]);
          mismatches++;
        end
        if (m_tdata[15:13] !== 3'b000) begin
          $display("%0t: tdata padding expected 0 actual %b", $time, m_tdata[15:13]);
          mismatches++;
        end
        if (m_tlast !== e.last) begin
          $display("%0t: last_of_run expected %0d actual %0d", $time, e.last, m_tlast);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time,
                 tok_expect_q.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    push_text("char*p=");
    push_text("+++");
    push_eot();
    push_byte("\"");
    push_text("\\n\\\"");
    push_byte(8'hff);
    push_byte(8'h00);
    push_byte("\"");
    push_text("/x//");
    push_byte(8'h0a);
    push_text("'\\");
    push_eot();
    push_eot();
    push_text("int");
    push_eot();
    while (text_q.size() < RANDOM_BYTES) push_random_token();
    push_eot();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (text_q.size() != 0) @(posedge clk);
    while (tok_expect_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d source bytes including %0d end-of-text marks; checked %0d results.",
             bytes_sent, eot_sent, tokens_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/csl_pkg.sv
hdl/csl_front.sv
hdl/csl_queue.sv
hdl/csl_back.sv
hdl/c_subset_lexer.sv
sim/tb_c_subset_lexer.sv
